[design/v3a_pkg.sv]
`timescale 1ns / 1ps

package v3a_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int MODE_W    = 4;
	localparam int STAT_W    = 2;

	localparam logic [MODE_W-1:0] MODE_ADD   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_SUB   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_NEG   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_DOT   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_CROSS = 4'd4;
	localparam logic [MODE_W-1:0] MODE_SCALE = 4'd5;
	localparam logic [MODE_W-1:0] MODE_DIV   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_MAG   = 4'd7;
	localparam logic [MODE_W-1:0] MODE_NORM  = 4'd8;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

endpackage

[design/v3a_in_if.sv]
`timescale 1ns / 1ps

interface v3a_in_if #(parameter int W = v3a_pkg::WORD_BITS) ();
	logic                        valid;
	logic                        ready;
	logic [v3a_pkg::MODE_W-1:0]  mode;
	logic signed [W-1:0]         ax;
	logic signed [W-1:0]         ay;
	logic signed [W-1:0]         az;
	logic signed [W-1:0]         bx;
	logic signed [W-1:0]         by;
	logic signed [W-1:0]         bz;
	logic signed [W-1:0]         scalar_k;

	modport source (output valid, mode, ax, ay, az, bx, by, bz, scalar_k, input ready);
	modport sink   (input valid, mode, ax, ay, az, bx, by, bz, scalar_k, output ready);
endinterface

[design/v3a_out_if.sv]
`timescale 1ns / 1ps

interface v3a_out_if #(parameter int W = v3a_pkg::WORD_BITS) ();
	logic                        valid;
	logic                        ready;
	logic signed [W-1:0]         rx;
	logic signed [W-1:0]         ry;
	logic signed [W-1:0]         rz;
	logic signed [W-1:0]         scalar_out;
	logic [v3a_pkg::STAT_W-1:0]  status;

	modport source (output valid, rx, ry, rz, scalar_out, status, input ready);
	modport sink   (input valid, rx, ry, rz, scalar_out, status, output ready);
endinterface

[design/vector3_alu_top.sv]
`timescale 1ns / 1ps

// Three-component vector unit in signed fixed point (WORD_BITS wide, FRAC_BITS fraction
// bits). One request enters per cycle unless the chain is stalled; each gives one result
// and, whatever the mode, passes through the multiply, sum and round stages, one cell per
// root bit of the square-root chain, one cell per quotient bit of the three divider
// lanes, and the output register. All requests travel the whole chain, so results
// leave in order. A held result stalls the whole chain only while the last divider
// cell also holds a request; an empty last cell lets the chain keep moving.
module vector3_alu_top #(
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS,
	parameter int WORD_BITS = v3a_pkg::WORD_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	v3a_in_if.sink   in_ch,
	v3a_out_if.source out_ch
);

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int N = W + F;
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [2*W+2:0] RND_HALF = (2*W+3)'(1) <<< (F-1);

	typedef struct packed {
		logic [v3a_pkg::MODE_W-1:0] mode;
		logic [2:0][W-1:0]          r;
		logic [W-1:0]               sc;
		logic                       sat;
		logic [2:0]                 an;
		logic                       kneg;
		logic [2:0][W-1:0]          aabs;
		logic [W-1:0]               dv;
		logic                       dz;
	} side_t;

	logic adv;
	logic out_load;
	logic acc;
	logic v_fin;

	// stage 1: operand select, multiply, add/sub/negate
	logic signed [W-1:0] av [3];
	logic signed [W-1:0] bv [3];
	logic signed [W-1:0] ma [6];
	logic signed [W-1:0] mb [6];
	logic [W:0]          e  [3];
	side_t               sd_1;

	logic                  v_s1;
	logic signed [2*W-1:0] p_s1 [6];
	side_t                 side_s1;

	assign acc = in_ch.valid & in_ch.ready;
	assign in_ch.ready = adv;

	always_comb begin
		av[0] = in_ch.ax; av[1] = in_ch.ay; av[2] = in_ch.az;
		bv[0] = in_ch.bx; bv[1] = in_ch.by; bv[2] = in_ch.bz;
		for (int i = 0; i < 3; i++) begin
			ma[i]   = av[i];
			mb[i]   = bv[i];
			ma[i+3] = '0;
			mb[i+3] = '0;
		end
		case (in_ch.mode)
			v3a_pkg::MODE_CROSS: begin
				ma[0] = av[1]; mb[0] = bv[2]; ma[3] = av[2]; mb[3] = bv[1];
				ma[1] = av[2]; mb[1] = bv[0]; ma[4] = av[0]; mb[4] = bv[2];
				ma[2] = av[0]; mb[2] = bv[1]; ma[5] = av[1]; mb[5] = bv[0];
			end
			v3a_pkg::MODE_SCALE: begin
				for (int i = 0; i < 3; i++) mb[i] = in_ch.scalar_k;
			end
			v3a_pkg::MODE_MAG, v3a_pkg::MODE_NORM: begin
				for (int i = 0; i < 3; i++) mb[i] = av[i];
			end
			default: ;
		endcase

		sd_1      = '0;
		sd_1.mode = in_ch.mode;
		sd_1.kneg = in_ch.scalar_k[W-1];
		sd_1.dv   = in_ch.scalar_k[W-1] ? W'(0) - in_ch.scalar_k : in_ch.scalar_k;
		for (int i = 0; i < 3; i++) begin
			case (in_ch.mode)
				v3a_pkg::MODE_ADD: e[i] = {av[i][W-1], av[i]} + {bv[i][W-1], bv[i]};
				v3a_pkg::MODE_SUB: e[i] = {av[i][W-1], av[i]} - {bv[i][W-1], bv[i]};
				v3a_pkg::MODE_NEG: e[i] = (W+1)'(0) - {av[i][W-1], av[i]};
				default:           e[i] = '0;
			endcase
			sd_1.an[i]   = av[i][W-1];
			sd_1.aabs[i] = av[i][W-1] ? W'(0) - av[i] : av[i];
			if (e[i][W] != e[i][W-1]) begin
				sd_1.r[i] = e[i][W] ? WMIN : WMAX;
				sd_1.sat  = 1'b1;
			end else begin
				sd_1.r[i] = e[i][W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) p_s1[i] <= ma[i] * mb[i];
			side_s1 <= sd_1;
		end
	end

	// stage 2: wide sums
	logic                  v_s2;
	logic signed [2*W+1:0] wide_s2 [3];
	side_t                 side_s2;
	logic signed [2*W+1:0] wsel [3];

	always_comb begin
		for (int i = 0; i < 3; i++) wsel[i] = '0;
		case (side_s1.mode)
			v3a_pkg::MODE_CROSS: begin
				for (int i = 0; i < 3; i++) wsel[i] = p_s1[i] - p_s1[i+3];
			end
			v3a_pkg::MODE_SCALE: begin
				for (int i = 0; i < 3; i++) wsel[i] = p_s1[i];
			end
			default: wsel[0] = p_s1[0] + p_s1[1] + p_s1[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) wide_s2[i] <= wsel[i];
			side_s2 <= side_s1;
		end
	end

	// stage 3: round and saturate products
	logic signed [2*W+2:0] rt  [3];
	logic [W-1:0]          rnd [3];
	logic [2:0]            rsat;
	side_t                 sd_3;

	logic           v_s3;
	logic [2*W-1:0] rad_s3;
	side_t          side_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rt[i] = ($signed({wide_s2[i][2*W+1], wide_s2[i]}) + RND_HALF) >>> F;
			if ((&rt[i][2*W+2:W-1]) || !(|rt[i][2*W+2:W-1])) begin
				rnd[i]  = rt[i][W-1:0];
				rsat[i] = 1'b0;
			end else begin
				rnd[i]  = rt[i][2*W+2] ? WMIN : WMAX;
				rsat[i] = 1'b1;
			end
		end
		sd_3 = side_s2;
		case (side_s2.mode)
			v3a_pkg::MODE_DOT: begin
				sd_3.sc  = rnd[0];
				sd_3.sat = rsat[0];
			end
			v3a_pkg::MODE_CROSS, v3a_pkg::MODE_SCALE: begin
				for (int i = 0; i < 3; i++) sd_3.r[i] = rnd[i];
				sd_3.sat = |rsat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= wide_s2[0][2*W-1:0];
			side_s3 <= sd_3;
		end
	end

	// square-root chain: one root bit per cell
	logic [2*W-1:0] sq_rad_q  [W];
	logic [W:0]     sq_rem_q  [W];
	logic [W-1:0]   sq_root_q [W];
	side_t          sq_sd_q   [W];
	logic           sq_v_q    [W];

	for (genvar j = 0; j < W; j++) begin : g_sq
		logic [2*W-1:0] rad_i;
		logic [W:0]     rem_i;
		logic [W-1:0]   root_i;
		side_t          sd_i;
		logic           v_i;

		if (j == 0) begin : g_head
			assign rad_i  = rad_s3;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sd_i   = side_s3;
			assign v_i    = v_s3;
		end else begin : g_link
			assign rad_i  = sq_rad_q[j-1];
			assign rem_i  = sq_rem_q[j-1];
			assign root_i = sq_root_q[j-1];
			assign sd_i   = sq_sd_q[j-1];
			assign v_i    = sq_v_q[j-1];
		end

		v3a_sqrt_cell #(.W(W)) u_cell (
			.clk    (clk),
			.en     (adv),
			.rad    (rad_i),
			.rem    (rem_i),
			.root   (root_i),
			.rad_q  (sq_rad_q[j]),
			.rem_q  (sq_rem_q[j]),
			.root_q (sq_root_q[j])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_q[j] <= 1'b0;
			end else if (adv) begin
				sq_v_q[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_sd_q[j] <= sd_i;
			end
		end
	end

	// pick divisor and magnitude
	logic [W-1:0] root_fin;
	side_t        sd_b;

	always_comb begin
		root_fin = sq_root_q[W-1];
		sd_b     = sq_sd_q[W-1];
		case (sd_b.mode)
			v3a_pkg::MODE_MAG: begin
				sd_b.sc  = root_fin[W-1] ? WMAX : root_fin;
				sd_b.sat = root_fin[W-1];
			end
			v3a_pkg::MODE_NORM: begin
				sd_b.dv = root_fin;
				sd_b.dz = (root_fin == '0);
			end
			v3a_pkg::MODE_DIV: begin
				sd_b.dz = (sd_b.dv == '0);
			end
			default: ;
		endcase
	end

	// divider chain: one quotient bit per cell, three lanes
	logic [W-1:0] dv_rem_q [3][N];
	logic [N-1:0] dv_nq_q  [3][N];
	side_t        dv_sd_q  [N];
	logic         dv_v_q   [N];

	for (genvar j = 0; j < N; j++) begin : g_dv
		side_t sd_i;
		logic  v_i;

		if (j == 0) begin : g_head
			assign sd_i = sd_b;
			assign v_i  = sq_v_q[W-1];
		end else begin : g_link
			assign sd_i = dv_sd_q[j-1];
			assign v_i  = dv_v_q[j-1];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [W-1:0] rem_i;
			logic [N-1:0] nq_i;

			if (j == 0) begin : g_head
				assign rem_i = '0;
				assign nq_i  = {sd_b.aabs[l], {F{1'b0}}};
			end else begin : g_link
				assign rem_i = dv_rem_q[l][j-1];
				assign nq_i  = dv_nq_q[l][j-1];
			end

			v3a_div_cell #(.W(W), .N(N)) u_cell (
				.clk   (clk),
				.en    (adv),
				.d     (sd_i.dv),
				.rem   (rem_i),
				.nq    (nq_i),
				.rem_q (dv_rem_q[l][j]),
				.nq_q  (dv_nq_q[l][j])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_q[j] <= 1'b0;
			end else if (adv) begin
				dv_v_q[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_sd_q[j] <= sd_i;
			end
		end
	end

	// sign, saturate quotients and form status
	side_t                      sd_f;
	logic [N-1:0]               q [3];
	logic                       qneg;
	logic                       hi_nz;
	logic [v3a_pkg::STAT_W-1:0] st_f;

	always_comb begin
		sd_f = dv_sd_q[N-1];
		for (int l = 0; l < 3; l++) begin
			q[l]  = dv_nq_q[l][N-1];
			qneg  = sd_f.an[l] ^ ((sd_f.mode == v3a_pkg::MODE_DIV) & sd_f.kneg);
			hi_nz = |q[l][N-1:W];
			if (sd_f.mode == v3a_pkg::MODE_DIV || sd_f.mode == v3a_pkg::MODE_NORM) begin
				if (qneg) begin
					if (hi_nz || (q[l][W-1] && (|q[l][W-2:0]))) begin
						sd_f.r[l] = WMIN;
						sd_f.sat  = 1'b1;
					end else begin
						sd_f.r[l] = W'(0) - q[l][W-1:0];
					end
				end else begin
					if (hi_nz || q[l][W-1]) begin
						sd_f.r[l] = WMAX;
						sd_f.sat  = 1'b1;
					end else begin
						sd_f.r[l] = q[l][W-1:0];
					end
				end
			end
		end
		if (sd_f.dz) begin
			st_f = v3a_pkg::ST_ZERO;
			sd_f.r  = '0;
			sd_f.sc = '0;
		end else if (sd_f.sat) begin
			st_f = v3a_pkg::ST_SAT;
		end else begin
			st_f = v3a_pkg::ST_OK;
		end
	end

	// output register
	logic                       out_v_q;
	logic [W-1:0]               rx_q;
	logic [W-1:0]               ry_q;
	logic [W-1:0]               rz_q;
	logic [W-1:0]               sc_q;
	logic [v3a_pkg::STAT_W-1:0] st_q;

	assign v_fin    = dv_v_q[N-1];
	assign out_load = !out_v_q || out_ch.ready;
	assign adv      = out_load || !v_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= v_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rx_q <= sd_f.r[0];
			ry_q <= sd_f.r[1];
			rz_q <= sd_f.r[2];
			sc_q <= sd_f.sc;
			st_q <= st_f;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.rx         = rx_q;
	assign out_ch.ry         = ry_q;
	assign out_ch.rz         = rz_q;
	assign out_ch.scalar_out = sc_q;
	assign out_ch.status     = st_q;

	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == v3a_pkg::ST_ZERO |->
			out_ch.rx == '0 && out_ch.ry == '0 && out_ch.rz == '0 && out_ch.scalar_out == '0)
		else $error("zero status with nonzero result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled with empty output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status != 2'd3)
		else $error("undefined status code");

endmodule

[design/v3a_sqrt_cell.sv]
`timescale 1ns / 1ps

module v3a_sqrt_cell #(
	parameter int W = v3a_pkg::WORD_BITS
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] rad,
	input  logic [W:0]     rem,
	input  logic [W-1:0]   root,
	output logic [2*W-1:0] rad_q,
	output logic [W:0]     rem_q,
	output logic [W-1:0]   root_q
);

	logic [W+2:0] rem_sh;
	logic [W+2:0] trial;
	logic [W+2:0] diff;
	logic         ge;

	always_comb begin
		rem_sh = {rem, rad[2*W-1 -: 2]};
		trial  = {1'b0, root, 2'b01};
		diff   = rem_sh - trial;
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad[2*W-3:0], 2'b00};
			rem_q  <= ge ? diff[W:0] : rem_sh[W:0];
			root_q <= {root[W-2:0], ge};
		end
	end

endmodule

[design/v3a_div_cell.sv]
`timescale 1ns / 1ps

module v3a_div_cell #(
	parameter int W = v3a_pkg::WORD_BITS,
	parameter int N = v3a_pkg::WORD_BITS + v3a_pkg::FRAC_BITS
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	input  logic [W-1:0] rem,
	input  logic [N-1:0] nq,
	output logic [W-1:0] rem_q,
	output logic [N-1:0] nq_q
);

	logic [W:0] rem_sh;
	logic [W:0] diff;
	logic       ge;

	always_comb begin
		rem_sh = {rem, nq[N-1]};
		diff   = rem_sh - {1'b0, d};
		ge     = (rem_sh >= {1'b0, d});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			nq_q  <= {nq[N-2:0], ge};
		end
	end

endmodule
